>>> src/swt_pkg.sv
package swt_pkg;

  // Character codes the tokenizer reacts to
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Most result records one input byte can give
  localparam int MaxRes = 3;
  localparam int CntW   = $clog2(MaxRes + 1);

  typedef enum logic [4:0] {
    MODE_PLAIN  = 5'b00001,
    MODE_ESC    = 5'b00010,
    MODE_SINGLE = 5'b00100,
    MODE_DOUBLE = 5'b01000,
    MODE_DESC   = 5'b10000
  } quote_mode_t;

  typedef struct packed {
    logic       line_end;
    logic       word_end;
    logic       byte_valid;
    logic [7:0] word_byte;
  } tok_res_t;

  typedef struct packed {
    tok_res_t [MaxRes-1:0] recs;
    logic [CntW-1:0]       count;
  } tok_group_t;

  function automatic tok_res_t mk_byte(input logic [7:0] b);
    tok_res_t r;
    r = '0;
    r.word_byte  = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

endpackage

>>> src/swt_decode.sv
module swt_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [7:0]        in_byte,
  input  logic              end_of_line,
  output swt_pkg::tok_group_t grp
);
  import swt_pkg::*;

  quote_mode_t     quote_mode, quote_mode_next;
  logic            word_open, word_open_next;
  tok_group_t      g;
  logic [CntW-1:0] n;
  tok_res_t        rec_end;

  always_comb begin
    g = '0;
    n = '0;
    rec_end = '0;
    quote_mode_next = quote_mode;
    word_open_next  = word_open;

    case (quote_mode)
      MODE_ESC: begin
        g.recs[n] = mk_byte(in_byte); n = n + CntW'(1); word_open_next = 1'b1;
        quote_mode_next = MODE_PLAIN;
      end
      MODE_SINGLE: begin
        if (in_byte == CH_SQUOTE) begin
          quote_mode_next = MODE_PLAIN;
        end else begin
          g.recs[n] = mk_byte(in_byte); n = n + CntW'(1); word_open_next = 1'b1;
        end
      end
      MODE_DOUBLE: begin
        if (in_byte == CH_DQUOTE) begin
          quote_mode_next = MODE_PLAIN;
        end else if (in_byte == CH_BSLASH) begin
          quote_mode_next = MODE_DESC;
        end else begin
          g.recs[n] = mk_byte(in_byte); n = n + CntW'(1); word_open_next = 1'b1;
        end
      end
      MODE_DESC: begin
        if (!(in_byte inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK, CH_NL})) begin
          g.recs[n] = mk_byte(CH_BSLASH); n = n + CntW'(1);
        end
        g.recs[n] = mk_byte(in_byte); n = n + CntW'(1); word_open_next = 1'b1;
        quote_mode_next = MODE_DOUBLE;
      end
      default: begin
        quote_mode_next = MODE_PLAIN;
        if (in_byte == CH_SPACE) begin
          if (word_open && !end_of_line) begin
            rec_end.word_end = 1'b1;
            g.recs[n] = rec_end; n = n + CntW'(1);
            word_open_next = 1'b0;
          end
        end else if (in_byte == CH_BSLASH) begin
          quote_mode_next = MODE_ESC;
        end else if (in_byte == CH_SQUOTE) begin
          quote_mode_next = MODE_SINGLE;
        end else if (in_byte == CH_DQUOTE) begin
          quote_mode_next = MODE_DOUBLE;
        end else begin
          g.recs[n] = mk_byte(in_byte); n = n + CntW'(1); word_open_next = 1'b1;
        end
      end
    endcase

    if (end_of_line) begin
      // Close an escape left hanging inside double quotes as a bare backslash
      if (quote_mode_next == MODE_DESC) begin
        g.recs[n] = mk_byte(CH_BSLASH); n = n + CntW'(1); word_open_next = 1'b1;
      end
      rec_end = '0;
      rec_end.word_end = word_open_next;
      rec_end.line_end = 1'b1;
      g.recs[n] = rec_end; n = n + CntW'(1);
      quote_mode_next = MODE_PLAIN;
      word_open_next  = 1'b0;
    end
    g.count = n;
  end

  assign grp = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= MODE_PLAIN;
      word_open  <= 1'b0;
    end else if (load) begin
      quote_mode <= quote_mode_next;
      word_open  <= word_open_next;
    end
  end

endmodule

>>> src/swt_out.sv
module swt_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  swt_pkg::tok_group_t grp,
  output logic                can_load,
  output swt_pkg::tok_res_t   head,
  output logic                head_valid,
  output logic                head_last,
  input  logic                head_ready
);
  import swt_pkg::*;

  tok_res_t [MaxRes-1:0] recs;
  logic [CntW-1:0]       left;
  logic                  pop;

  assign head       = recs[0];
  assign head_valid = (left != '0);
  assign head_last  = (left == CntW'(1));
  assign pop        = head_valid && head_ready;
  assign can_load   = !head_valid || (head_last && head_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= grp.count;
    end else if (pop) begin
      left <= left - CntW'(1);
    end
  end

  // Shift the queued records towards the head as each one is taken
  always_ff @(posedge clk) begin
    if (load) begin
      recs <= grp.recs;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        recs[i] <= recs[i+1];
      end
    end
  end

endmodule

>>> src/shell_word_tokenizer.sv
// Shell word tokenizer: splits a command line into words as a POSIX shell does.
// Input channel (s_*): one command-line byte per transfer in s_tdata[7:0];
//   s_tlast marks the last byte of the line.
// Output channel (m_*): one record per transfer. m_tuser high means
//   m_tdata[7:0] is a word byte; m_tdata[8] closes a non-empty word;
//   m_tdata[9] marks the end of the line. m_tlast flags the last record
//   caused by one input byte.
// Each input byte gives zero to three records. Spaces outside quotes split
//   words, backslash and quotes are handled per shell rules, unclosed quotes
//   are closed silently at end of line.
// Path: a byte is held in the input register, decoded combinationally, and
//   its records are registered into the output queue once the queue can take them.
// Throughput: one byte per cycle while each byte gives at most one record and
//   m_tready stays high; a byte with several records holds the decoder until its
//   last record is taken, the queue draining one record per cycle while m_tready is high.
// Reset (rst, synchronous) empties the input register and the output queue
//   and returns the quote state to plain with no word open.
// When m_tready is low the current record holds, the queue stops, and s_tready
//   drops once the input register holds a byte.
module shell_word_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_line
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] word_byte, [8] word_end, [9] line_end, zero above
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // run_last
);
  import swt_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eol;
  logic       can_load;
  logic       load;
  tok_group_t grp;
  tok_res_t   head;

  // Advance the input register to the decoder whenever the queue can take a group
  assign load     = in_valid && can_load;
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eol  <= s_tlast;
    end
  end

  swt_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .in_byte     (in_byte),
    .end_of_line (in_eol),
    .grp         (grp)
  );

  swt_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .grp        (grp),
    .can_load   (can_load),
    .head       (head),
    .head_valid (m_tvalid),
    .head_last  (m_tlast),
    .head_ready (m_tready)
  );

  assign m_tdata = {6'b0, head.line_end, head.word_end, head.word_byte};
  assign m_tuser = head.byte_valid;

endmodule

>>> src/swt_checker.sv
module swt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled record changed");

  // A line end is always the last record of its byte
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tlast)
    else $error("line end not last of run");

  // A word byte carries no end marks
  a_byte_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[8] && !m_tdata[9])
    else $error("word byte with end mark");

  // A record without a byte has a zero byte field and is an end record
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00 && (m_tdata[8] || m_tdata[9]))
    else $error("empty record malformed");

  // Nothing is offered straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> tb/sv/tb_top.sv
module tb_top;
  import swt_pkg::*;

  // One output record as the block presents it, one transfer each
  typedef struct packed {
    logic       run_last;
    logic       line_end;
    logic       word_end;
    logic       byte_valid;
    logic [7:0] word_byte;
  } word_rec_t;

  // One row of the directed stimulus table. Rows with n_typed set to PRED take their
  // expectation from the tokenizer model below; the others carry it typed in.
  typedef struct packed {
    logic [7:0]           chr;
    logic                 eol;
    int                   n_typed;
    word_rec_t [2:0]      recs;
  } stim_row_t;

  localparam int PRED        = -1;
  localparam int NDIR        = 27;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Tokenizer model state
  quote_mode_t pred_mode = MODE_PLAIN;
  logic        pred_word_open = 1'b0;

  word_rec_t   step_q [$];        // records caused by the byte just accepted
  word_rec_t   pending_recs [$];  // records still owed by the block

  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          ready_burst = 0;
  int          phase_items = 0;
  logic        gap_off = 1'b0;

  shell_word_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] in_byte
    .s_tlast  (s_tlast),   // end_of_line
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] word_byte, [8] word_end, [9] line_end
    .m_tuser  (m_tuser),   // byte_valid
    .m_tlast  (m_tlast)    // run_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_rec_t rbyte(input logic [7:0] b, input logic last);
    word_rec_t r;
    r = '0;
    r.word_byte  = b;
    r.byte_valid = 1'b1;
    r.run_last   = last;
    return r;
  endfunction

  function automatic word_rec_t rword_end(input logic last);
    word_rec_t r;
    r = '0;
    r.word_end = 1'b1;
    r.run_last = last;
    return r;
  endfunction

  // A line end is always the last record of its byte
  function automatic word_rec_t rline_end(input logic we);
    word_rec_t r;
    r = '0;
    r.line_end = 1'b1;
    r.word_end = we;
    r.run_last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [7:0] chr, input logic eol, input int n,
                                    input word_rec_t r0 = '0, input word_rec_t r1 = '0);
    stim_row_t s;
    s = '0;
    s.chr     = chr;
    s.eol     = eol;
    s.n_typed = n;
    s.recs[0] = r0;
    s.recs[1] = r1;
    return s;
  endfunction

  function automatic string rec_str(input word_rec_t r);
    return $sformatf("byte %02h bv %0b we %0b le %0b last %0b",
                     r.word_byte, r.byte_valid, r.word_end, r.line_end, r.run_last);
  endfunction

  function automatic void note_error(input string msg);
    if (err_cnt < 10)
      $display("ERROR @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endfunction

  // Append a word byte and open the word
  function automatic void put_byte(input logic [7:0] b);
    step_q.push_back(rbyte(b, 1'b0));
    pred_word_open = 1'b1;
  endfunction

  // Advance the tokenizer model by one byte; its records land in step_q
  function automatic void tokenize_byte(input logic [7:0] chr, input logic eol);
    word_rec_t last_rec;
    step_q.delete();
    case (pred_mode)
      MODE_ESC: begin
        put_byte(chr);
        pred_mode = MODE_PLAIN;
      end
      MODE_SINGLE: begin
        if (chr == CH_SQUOTE) pred_mode = MODE_PLAIN;
        else put_byte(chr);
      end
      MODE_DOUBLE: begin
        if (chr == CH_DQUOTE) pred_mode = MODE_PLAIN;
        else if (chr == CH_BSLASH) pred_mode = MODE_DESC;
        else put_byte(chr);
      end
      MODE_DESC: begin
        // Only the five special bytes swallow the backslash
        if (!(chr == CH_DQUOTE || chr == CH_BSLASH || chr == CH_DOLLAR ||
              chr == CH_BTICK || chr == CH_NL))
          put_byte(CH_BSLASH);
        put_byte(chr);
        pred_mode = MODE_DOUBLE;
      end
      default: begin
        pred_mode = MODE_PLAIN;
        if (chr == CH_SPACE) begin
          if (pred_word_open && !eol) begin
            step_q.push_back(rword_end(1'b0));
            pred_word_open = 1'b0;
          end
        end else if (chr == CH_BSLASH) begin
          pred_mode = MODE_ESC;
        end else if (chr == CH_SQUOTE) begin
          pred_mode = MODE_SINGLE;
        end else if (chr == CH_DQUOTE) begin
          pred_mode = MODE_DOUBLE;
        end else begin
          put_byte(chr);
        end
      end
    endcase
    if (eol) begin
      // A pending escape inside double quotes still gives its backslash;
      // an outer one is dropped, an open quote closes silently.
      if (pred_mode == MODE_DESC)
        put_byte(CH_BSLASH);
      step_q.push_back(rline_end(pred_word_open));
      pred_mode      = MODE_PLAIN;
      pred_word_open = 1'b0;
    end
    if (step_q.size() > 0) begin
      last_rec = step_q.pop_back();
      last_rec.run_last = 1'b1;
      step_q.push_back(last_rec);
    end
  endfunction

  // Bias toward the bytes that drive the quoting rules
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0, 1, 2: return CH_SPACE;
      3, 4:    return CH_BSLASH;
      5:       return CH_SQUOTE;
      6, 7:    return CH_DQUOTE;
      8:       return CH_DOLLAR;
      9:       return CH_BTICK;
      10:      return CH_NL;
      11, 12, 13: return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one byte, hold it until the block takes it, then book its records
  task automatic send_byte(input stim_row_t r);
    if (!gap_off && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.chr;
    s_tlast  <= r.eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokenize_byte(r.chr, r.eol);
    if (r.n_typed == PRED) begin
      foreach (step_q[i]) pending_recs.push_back(step_q[i]);
    end else begin
      for (int i = 0; i < r.n_typed; i++) pending_recs.push_back(r.recs[i]);
    end
  endtask

  // One command line; noise lines are fully random bytes
  task automatic send_line(input logic noise);
    int len;
    stim_row_t r;
    len     = $urandom_range(1, 12);
    gap_off = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      r = '0;
      r.chr     = noise ? 8'($urandom_range(0, 255)) : pick_char();
      r.eol     = (k == len - 1);
      r.n_typed = PRED;
      send_byte(r);
      phase_items++;
    end
  endtask

  // Receiver: random stalls, ready bursts, and one long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (ready_burst > 0) begin
      ready_burst--;
      m_tready <= 1'b1;
    end else begin
      if ($urandom_range(0, 31) == 0)
        ready_burst = $urandom_range(8, 24);
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check every record transfer against the oldest expectation
  always @(posedge clk) begin : rec_check
    word_rec_t got;
    word_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.word_byte  = m_tdata[7:0];
      got.word_end   = m_tdata[8];
      got.line_end   = m_tdata[9];
      got.byte_valid = m_tuser;
      got.run_last   = m_tlast;
      if (pending_recs.size() == 0) begin
        note_error({"unexpected record: ", rec_str(got)});
      end else begin
        want = pending_recs.pop_front();
        if (got.word_byte !== want.word_byte || got.byte_valid !== want.byte_valid ||
            got.word_end !== want.word_end || got.line_end !== want.line_end ||
            got.run_last !== want.run_last)
          note_error({"expected ", rec_str(want), ", got ", rec_str(got)});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TIMEOUT with %0d records outstanding", pending_recs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [NDIR];
    dir_rows = '{
      row(8'h00,     1'b1, 2, rbyte(8'h00, 1'b0), rline_end(1'b1)),  // zero byte, one-byte line
      row(CH_SPACE,  1'b1, 1, rline_end(1'b0)),                      // lone space line
      row(8'hFF,     1'b0, 1, rbyte(8'hFF, 1'b1)),
      row(CH_SPACE,  1'b0, 1, rword_end(1'b1)),
      row(CH_BSLASH, 1'b0, 0),                                       // outer escape
      row(CH_SPACE,  1'b0, PRED),                                    // escaped space
      row(CH_SQUOTE, 1'b0, PRED),
      row(CH_DQUOTE, 1'b0, PRED),                                    // literal in single quotes
      row(CH_BSLASH, 1'b0, PRED),
      row(CH_SQUOTE, 1'b0, PRED),
      row(CH_DQUOTE, 1'b0, PRED),
      row(CH_BSLASH, 1'b0, PRED),
      row(CH_DOLLAR, 1'b0, PRED),                                    // special after backslash
      row(CH_BSLASH, 1'b0, PRED),
      row(8'h61,     1'b0, PRED),                                    // ordinary: both bytes
      row(CH_BSLASH, 1'b0, PRED),
      row(CH_DQUOTE, 1'b0, PRED),
      row(CH_BSLASH, 1'b0, PRED),
      row(CH_BSLASH, 1'b0, PRED),
      row(CH_DQUOTE, 1'b0, PRED),
      row(CH_SPACE,  1'b1, 1, rline_end(1'b1)),                      // space on last byte
      row(CH_DQUOTE, 1'b0, PRED),                                    // empty quotes
      row(CH_DQUOTE, 1'b0, PRED),
      row(CH_SQUOTE, 1'b1, 1, rline_end(1'b0)),                      // unclosed quote
      row(CH_DQUOTE, 1'b0, PRED),
      row(CH_BSLASH, 1'b1, 2, rbyte(CH_BSLASH, 1'b0), rline_end(1'b1)),
      row(CH_BSLASH, 1'b1, 1, rline_end(1'b0))                       // trailing outer backslash
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling
    for (int i = 0; i < NDIR; i++) send_byte(dir_rows[i]);

    // Random lines over four idling phases; the first opens with a long receiver hold-off
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_req  <= hold_req + 1;
        end
        1: begin
          idle_pct = 65;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 65;
        end
        default: begin
          idle_pct = 24;
          stall_pct <= 24;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_line($urandom_range(0, 4) == 0);
    end

    s_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
